@@ rtl/core/rtt_est_pkg.sv @@
package rtt_est_pkg;

    // Field widths
    localparam int TIME_W   = 24;
    localparam int ALPHA_W  = 16;
    localparam int BETA_W   = 12;
    localparam int OPA_W    = ALPHA_W + 1;
    localparam int ACC_W    = OPA_W + TIME_W;
    localparam int ADDEND_W = 16;
    localparam int TSUM_W   = 29;

    // Register indexes
    localparam logic [1:0] REG_SMOOTHING_WEIGHT = 2'd0;
    localparam logic [1:0] REG_VARIANCE_GAIN    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_FLOOR    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_CEILING  = 2'd3;

    // Reset values of the registers
    localparam logic [ALPHA_W-1:0] SMOOTHING_WEIGHT_RST = 16'd8192;
    localparam logic [BETA_W-1:0]  VARIANCE_GAIN_RST    = 12'd384;
    localparam logic [TIME_W-1:0]  TIMEOUT_FLOOR_RST    = 24'd51200;
    localparam logic [TIME_W-1:0]  TIMEOUT_CEILING_RST  = 24'd15360000;

    // Rounding constants and unity gain
    localparam logic [ADDEND_W-1:0] ROUND_BLEND = 16'd32768;
    localparam logic [ADDEND_W-1:0] ROUND_GAIN  = 16'd128;
    localparam logic [OPA_W-1:0]    ALPHA_ONE   = 17'd65536;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_VAR_OLD,
        ST_VAR_NEW,
        ST_SRTT_OLD,
        ST_SRTT_NEW,
        ST_GAIN,
        ST_SUM,
        ST_CLAMP
    } seq_state_t;

    // Controls of the shared multiply-accumulate unit
    typedef struct packed {
        logic                en;
        logic                clear;
        logic [OPA_W-1:0]    op_a;
        logic [TIME_W-1:0]   op_b;
        logic [ADDEND_W-1:0] addend;
    } mac_ctrl_t;

endpackage

@@ rtl/core/rtt_est_mac.sv @@
module rtt_est_mac
    import rtt_est_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_ctrl_t        ctrl,
    output logic [ACC_W-1:0] sum,
    output logic [ACC_W-1:0] acc
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] product;

    // One multiply plus accumulate per cycle
    assign product = ACC_W'(ctrl.op_a) * ACC_W'(ctrl.op_b);
    assign sum     = (ctrl.clear ? '0 : acc_reg) + product + ACC_W'(ctrl.addend);
    assign acc     = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.en)
        begin
            acc_reg <= sum;
        end
    end

endmodule

@@ rtl/core/rtt_smoothing_rto_estimator_core.sv @@
// RTT smoother and retransmission timeout estimator.
// Input channel: in_valid/in_ready carry one rtt_sample (Q16.8 ms) per transaction.
// Output channel: out_valid/out_ready carry timeout_value, smoothed_rtt and
// rtt_variance for that sample; exactly one result per input.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 alpha Q0.16,
// 1 beta Q4.8, 2 timeout floor, 3 timeout ceiling); write only while idle.
// Datapath: every multiply runs through one shared 17x24 multiply-accumulate unit.
// The first sample after reset goes through the gain product, the sum and the
// clamp steps before the result is registered; later samples first go through
// the error step and two blend passes (old and new term each). in_ready is high
// only while the sequencer is idle, so a new sample waits until the last one has left the clamp step.
// The result sits in an output register: a new sample is accepted while it
// waits, and if the receiver still stalls when the next result is done, the
// sequencer holds in its clamp step until the output register frees up.
// Reset clears the first-sample flag, the estimates and the registers to
// their defaults (alpha 0.125, beta 1.5, floor 200 ms, ceiling 60000 ms).
module rtt_smoothing_rto_estimator_core
    import rtt_est_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TIME_W-1:0] rtt_sample,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] timeout_value,
    output logic [TIME_W-1:0] smoothed_rtt,
    output logic [TIME_W-1:0] rtt_variance
);

    seq_state_t state_reg, state_next;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [BETA_W-1:0]  beta_reg;
    logic [TIME_W-1:0]  floor_reg;
    logic [TIME_W-1:0]  ceiling_reg;

    logic               seen_first_sample_reg;
    logic [TIME_W-1:0]  srtt_reg;
    logic [TIME_W-1:0]  var_reg;
    logic [TIME_W-1:0]  sample_reg;
    logic [TIME_W-1:0]  err_reg;
    logic [TSUM_W-1:0]  tsum_reg;

    logic               out_valid_reg;
    logic [TIME_W-1:0]  timeout_reg;
    logic [TIME_W-1:0]  srtt_out_reg;
    logic [TIME_W-1:0]  var_out_reg;

    mac_ctrl_t          mac_ctrl;
    logic [ACC_W-1:0]   mac_sum;
    logic [ACC_W-1:0]   mac_acc;

    logic               in_fire;
    logic               out_load;
    logic [OPA_W-1:0]   alpha_comp;
    logic [TSUM_W-1:0]  tsum_floored;
    logic [TSUM_W-1:0]  tsum_clamped;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign alpha_comp = ALPHA_ONE - OPA_W'(alpha_reg);

    rtt_est_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .sum   (mac_sum),
        .acc   (mac_acc)
    );

    // Clamp: floor first, then ceiling wins
    always_comb
    begin
        tsum_floored = (tsum_reg < TSUM_W'(floor_reg)) ? TSUM_W'(floor_reg) : tsum_reg;
        tsum_clamped = (tsum_floored > TSUM_W'(ceiling_reg)) ? TSUM_W'(ceiling_reg)
                                                             : tsum_floored;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = seen_first_sample_reg ? ST_ERR : ST_GAIN;
                end
            end
            ST_ERR:      state_next = ST_VAR_OLD;
            ST_VAR_OLD:  state_next = ST_VAR_NEW;
            ST_VAR_NEW:  state_next = ST_SRTT_OLD;
            ST_SRTT_OLD: state_next = ST_SRTT_NEW;
            ST_SRTT_NEW: state_next = ST_GAIN;
            ST_GAIN:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // MAC controls and output load
    always_comb
    begin
        mac_ctrl = '0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_VAR_OLD:
            begin
                mac_ctrl.en     = 1'b1;
                mac_ctrl.clear  = 1'b1;
                mac_ctrl.op_a   = alpha_comp;
                mac_ctrl.op_b   = var_reg;
                mac_ctrl.addend = ROUND_BLEND;
            end
            ST_VAR_NEW:
            begin
                mac_ctrl.op_a = OPA_W'(alpha_reg);
                mac_ctrl.op_b = err_reg;
            end
            ST_SRTT_OLD:
            begin
                mac_ctrl.en     = 1'b1;
                mac_ctrl.clear  = 1'b1;
                mac_ctrl.op_a   = alpha_comp;
                mac_ctrl.op_b   = srtt_reg;
                mac_ctrl.addend = ROUND_BLEND;
            end
            ST_SRTT_NEW:
            begin
                mac_ctrl.op_a = OPA_W'(alpha_reg);
                mac_ctrl.op_b = sample_reg;
            end
            ST_GAIN:
            begin
                mac_ctrl.en     = 1'b1;
                mac_ctrl.clear  = 1'b1;
                mac_ctrl.op_a   = OPA_W'(beta_reg);
                mac_ctrl.op_b   = var_reg;
                mac_ctrl.addend = ROUND_GAIN;
            end
            ST_CLAMP:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            seen_first_sample_reg <= 1'b0;
            srtt_reg              <= '0;
            var_reg               <= '0;
            out_valid_reg         <= 1'b0;
            alpha_reg             <= SMOOTHING_WEIGHT_RST;
            beta_reg              <= VARIANCE_GAIN_RST;
            floor_reg             <= TIMEOUT_FLOOR_RST;
            ceiling_reg           <= TIMEOUT_CEILING_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SMOOTHING_WEIGHT: alpha_reg   <= cfg_data[ALPHA_W-1:0];
                    REG_VARIANCE_GAIN:    beta_reg    <= cfg_data[BETA_W-1:0];
                    REG_TIMEOUT_FLOOR:    floor_reg   <= cfg_data;
                    REG_TIMEOUT_CEILING:  ceiling_reg <= cfg_data;
                    default:              alpha_reg   <= alpha_reg;
                endcase
            end

            // Estimates
            if (in_fire && !seen_first_sample_reg)
            begin
                seen_first_sample_reg <= 1'b1;
                srtt_reg              <= rtt_sample;
                var_reg               <= rtt_sample >> 1;
            end
            if (state_reg == ST_VAR_NEW)
            begin
                var_reg <= mac_sum[TIME_W+ALPHA_W-1:ALPHA_W];
            end
            if (state_reg == ST_SRTT_NEW)
            begin
                srtt_reg <= mac_sum[TIME_W+ALPHA_W-1:ALPHA_W];
            end

            // Output valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= rtt_sample;
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= (sample_reg >= srtt_reg) ? sample_reg - srtt_reg
                                                : srtt_reg - sample_reg;
        end
        if (state_reg == ST_SUM)
        begin
            tsum_reg <= TSUM_W'(srtt_reg) + mac_acc[TSUM_W+7:8];
        end
        if (out_load)
        begin
            timeout_reg  <= tsum_clamped[TIME_W-1:0];
            srtt_out_reg <= srtt_reg;
            var_out_reg  <= var_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign timeout_value = timeout_reg;
    assign smoothed_rtt  = srtt_out_reg;
    assign rtt_variance  = var_out_reg;

    // An accepted sample leaves the first-sample flag set
    a_first_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> seen_first_sample_reg)
        else $error("first-sample flag not set after a sample");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result load did not raise out_valid");

    a_blend_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VAR_NEW || state_reg == ST_SRTT_NEW)
            |-> mac_sum[ACC_W-1:TIME_W+ALPHA_W] == '0)
        else $error("blend result exceeds the time width");

    a_clamp_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLAMP |-> tsum_clamped <= TSUM_W'(ceiling_reg))
        else $error("timeout above ceiling");

    a_stall_holds_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLAMP && out_valid_reg && !out_ready) |=> state_reg == ST_CLAMP)
        else $error("sequencer left clamp step while output stalled");

endmodule

@@ tb/rtt_smoothing_rto_estimator_core_tb.sv @@
`timescale 1ns / 1ps

module rtt_smoothing_rto_estimator_core_tb;
    import rtt_est_pkg::*;

    localparam int LIMIT_CYCLES    = 500000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int QUIET_PHASE     = 2;
    localparam int PRESSURE_AT     = 900;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 12;
    localparam int IDLE_PCT        = 12;

    localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;

    // which fields of a directed row carry a hand-typed expectation
    localparam logic [2:0] KNOWN_NONE   = 3'b000;
    localparam logic [2:0] KNOWN_RTO    = 3'b100;
    localparam logic [2:0] KNOWN_SRTT   = 3'b010;
    localparam logic [2:0] KNOWN_RTTVAR = 3'b001;
    localparam logic [2:0] KNOWN_ALL    = 3'b111;

    typedef struct packed {
        logic [TIME_W-1:0] rto;
        logic [TIME_W-1:0] srtt;
        logic [TIME_W-1:0] rttvar;
    } rto_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_SETTINGS} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [3:0][TIME_W-1:0] val;    // sample in val[0], or the four register values
        logic [2:0]             known;
        rto_result_t            known_res;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [TIME_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [TIME_W-1:0] rtt_sample;
    logic              out_valid;
    logic              out_ready;
    logic [TIME_W-1:0] timeout_value;
    logic [TIME_W-1:0] smoothed_rtt;
    logic [TIME_W-1:0] rtt_variance;

    // shadow of the estimator state and its registers
    logic              est_seen;
    logic [TIME_W-1:0] est_srtt;
    logic [TIME_W-1:0] est_var;
    logic [ALPHA_W-1:0] gain_alpha;
    logic [BETA_W-1:0]  gain_beta;
    logic [TIME_W-1:0]  clamp_floor;
    logic [TIME_W-1:0]  clamp_ceiling;

    rto_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    int          n_errors   = 0;
    int          n_accepted = 0;
    int          cycle_count = 0;
    bit          quiet_phase = 1'b0;

    rtt_smoothing_rto_estimator_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rtt_sample   (rtt_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .timeout_value(timeout_value),
        .smoothed_rtt (smoothed_rtt),
        .rtt_variance (rtt_variance)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("rtt_smoothing_rto_estimator_core_tb: done, errors");
            $finish;
        end
    end

    // rounded Q0.16 weighted mean of two times
    function automatic logic [TIME_W-1:0] blend_q16(input logic [TIME_W-1:0] prev,
                                                    input logic [TIME_W-1:0] cur,
                                                    input logic [ALPHA_W-1:0] a);
        logic [63:0] p;
        logic [63:0] c;
        logic [63:0] w;
        logic [63:0] acc;
        p = 64'(prev);
        c = 64'(cur);
        w = 64'(a);
        acc = (64'd65536 - w) * p + w * c + 64'd32768;
        return acc[16 +: TIME_W];
    endfunction

    // advance the shadow estimator by one sample and return its outputs
    task automatic advance_estimator(input logic [TIME_W-1:0] s, output rto_result_t r);
        logic [TIME_W-1:0] err;
        logic [63:0]       gain_term;
        logic [63:0]       total;
        if (!est_seen)
        begin
            est_srtt = s;
            est_var  = s >> 1;
            est_seen = 1'b1;
        end
        else
        begin
            err     = (s >= est_srtt) ? s - est_srtt : est_srtt - s;
            est_var  = blend_q16(est_var, err, gain_alpha);
            est_srtt = blend_q16(est_srtt, s, gain_alpha);
        end
        gain_term = ({52'd0, gain_beta} * {40'd0, est_var} + 64'd128) >> 8;
        total     = {40'd0, est_srtt} + gain_term;
        if (total < {40'd0, clamp_floor})
            total = {40'd0, clamp_floor};
        if (total > {40'd0, clamp_ceiling})
            total = {40'd0, clamp_ceiling};
        r.rto    = total[TIME_W-1:0];
        r.srtt   = est_srtt;
        r.rttvar = est_var;
    endtask

    // offer one sample, with random idle before it; record the expectation on acceptance
    task automatic send_sample(input logic [TIME_W-1:0] s, input logic [2:0] known,
                               input rto_result_t known_res);
        rto_result_t r;
        while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        rtt_sample <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_estimator(s, r);
        if (known[2])
            r.rto = known_res.rto;
        if (known[1])
            r.srtt = known_res.srtt;
        if (known[0])
            r.rttvar = known_res.rttvar;
        pending_results.push_back(r);
        n_accepted++;
    endtask

    // let every outstanding result drain, then give the sequencer time to go idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [TIME_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_SMOOTHING_WEIGHT: gain_alpha    = value[ALPHA_W-1:0];
            REG_VARIANCE_GAIN:    gain_beta     = value[BETA_W-1:0];
            REG_TIMEOUT_FLOOR:    clamp_floor   = value;
            REG_TIMEOUT_CEILING:  clamp_ceiling = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [3:0][TIME_W-1:0] v);
        settle();
        put_reg(REG_SMOOTHING_WEIGHT, v[0]);
        put_reg(REG_VARIANCE_GAIN,    v[1]);
        put_reg(REG_TIMEOUT_FLOOR,    v[2]);
        put_reg(REG_TIMEOUT_CEILING,  v[3]);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_sample(input logic [TIME_W-1:0] s, input logic [2:0] known,
                              input logic [TIME_W-1:0] rto, input logic [TIME_W-1:0] srtt,
                              input logic [TIME_W-1:0] rttvar);
        stim_row_t row;
        row.kind             = ROW_SAMPLE;
        row.val              = '0;
        row.val[0]           = s;
        row.known            = known;
        row.known_res.rto    = rto;
        row.known_res.srtt   = srtt;
        row.known_res.rttvar = rttvar;
        directed_rows.push_back(row);
    endtask

    task automatic add_settings(input logic [TIME_W-1:0] alpha, input logic [TIME_W-1:0] beta,
                                input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
        stim_row_t row;
        row.kind      = ROW_SETTINGS;
        row.val       = {hi, lo, beta, alpha};
        row.known     = KNOWN_NONE;
        row.known_res = '0;
        directed_rows.push_back(row);
    endtask

    // random sample: most often near the running estimate, plus small, full-range and extremes
    function automatic logic [TIME_W-1:0] pick_sample();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            v = int'(est_srtt) + int'($urandom_range(0, 4096)) - 2048;
            if (v < 0)
                v = 0;
            if (v > int'(TIME_MAX))
                v = int'(TIME_MAX);
            return v[TIME_W-1:0];
        end
        else if (sel < 70)
            return TIME_W'($urandom_range(0, 65535));
        else if (sel < 90)
            return TIME_W'($urandom());
        else
            return (sel[0]) ? TIME_MAX : '0;
    endfunction

    function automatic logic [3:0][TIME_W-1:0] pick_settings();
        logic [3:0][TIME_W-1:0] v;
        logic [TIME_W-1:0]      raw;
        raw = TIME_W'($urandom());
        case ($urandom_range(0, 3))
            0:       v[0] = {raw[23:16], 16'h0000};
            1:       v[0] = {raw[23:16], 16'hFFFF};
            default: v[0] = raw;
        endcase
        raw = TIME_W'($urandom());
        case ($urandom_range(0, 3))
            0:       v[1] = {raw[23:12], 12'h000};
            1:       v[1] = {raw[23:12], 12'hFFF};
            default: v[1] = raw;
        endcase
        case ($urandom_range(0, 3))
            0:       v[2] = '0;
            1:       v[2] = TIME_W'($urandom_range(0, 100000));
            default: v[2] = TIME_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0:       v[3] = TIME_MAX;
            1:       v[3] = TIME_W'($urandom_range(100000, 16777215));
            default: v[3] = TIME_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic void check_field(input string label, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
            n_errors++;
        end
    endfunction

    // result side: check each transaction, random stalls, one long hold-off
    initial
    begin : result_side
        rto_result_t want;
        int          hold_left;
        bit          pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: rto %0d srtt %0d var %0d",
                             $time, timeout_value, smoothed_rtt, rtt_variance);
                    n_errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("timeout_value", want.rto, timeout_value);
                    check_field("smoothed_rtt", want.srtt, smoothed_rtt);
                    check_field("rtt_variance", want.rttvar, rtt_variance);
                end
            end
            if (!pressure_done && n_accepted >= PRESSURE_AT)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (quiet_phase)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // stimulus side
    initial
    begin : stimulus
        stim_row_t row;
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= REG_SMOOTHING_WEIGHT;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        rtt_sample <= '0;
        est_seen      = 1'b0;
        est_srtt      = '0;
        est_var       = '0;
        gain_alpha    = SMOOTHING_WEIGHT_RST;
        gain_beta     = VARIANCE_GAIN_RST;
        clamp_floor   = TIMEOUT_FLOOR_RST;
        clamp_ceiling = TIMEOUT_CEILING_RST;

        // first sample after reset at full scale: sum runs past the default ceiling
        add_sample(TIME_MAX, KNOWN_ALL, 24'd15360000, TIME_MAX, 24'h7FFFFF);
        add_sample(24'd0, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd1, KNOWN_NONE, '0, '0, '0);
        add_sample(TIME_MAX, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd0, KNOWN_NONE, '0, '0, '0);
        // zero gain freezes the estimates
        add_settings(24'd0, 24'd384, 24'd0, TIME_MAX);
        add_sample(24'd123456, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd0, KNOWN_NONE, '0, '0, '0);
        add_sample(TIME_MAX, KNOWN_NONE, '0, '0, '0);
        // largest gain and largest beta, ceiling at full scale
        add_settings(24'd65535, 24'd4095, 24'd0, TIME_MAX);
        add_sample(TIME_MAX, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd0, KNOWN_NONE, '0, '0, '0);
        add_sample(TIME_MAX, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd1, KNOWN_NONE, '0, '0, '0);
        // upper data bits beyond the register width are dropped; beta becomes zero
        add_settings(24'hFF2000, 24'hFFF000, 24'd0, TIME_MAX);
        add_sample(24'd256, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd777777, KNOWN_NONE, '0, '0, '0);
        // floor above ceiling: the ceiling wins
        add_settings(24'd32768, 24'd256, TIME_MAX, 24'd0);
        add_sample(24'd0, KNOWN_RTO, 24'd0, '0, '0);
        add_sample(TIME_MAX, KNOWN_RTO, 24'd0, '0, '0);
        // floor equal to ceiling pins the timeout
        add_settings(24'd32768, 24'd256, 24'd5000, 24'd5000);
        add_sample(24'd0, KNOWN_RTO, 24'd5000, '0, '0);
        add_sample(TIME_MAX, KNOWN_RTO, 24'd5000, '0, '0);
        // back to the defaults
        add_settings(24'd8192, 24'd384, 24'd51200, 24'd15360000);
        add_sample(24'd25600, KNOWN_NONE, '0, '0, '0);
        add_sample(24'd30000, KNOWN_NONE, '0, '0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_SETTINGS)
                apply_settings(row.val);
            else
                send_sample(row.val[0], row.known, row.known_res);
        end

        // random phases, each under fresh register settings
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            apply_settings(pick_settings());
            quiet_phase = (ph == QUIET_PHASE);
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), KNOWN_NONE, '0);
        end
        quiet_phase = 1'b0;

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("rtt_smoothing_rto_estimator_core_tb: done, clean");
        else
            $display("rtt_smoothing_rto_estimator_core_tb: done, errors");
        $finish;
    end

endmodule
